// File: src/kmh_pkg.sv
`timescale 1ns / 1ps

package kmh_pkg;

	// Sizes
	localparam int NUM_SRC = 16;
	localparam int KEY_W   = 32;
	localparam int SRC_W   = $clog2(NUM_SRC);
	localparam int CNT_W   = $clog2(NUM_SRC + 1);
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;
	localparam int NSRC_W  = 5;

	// Result status codes
	localparam logic [1:0] ST_LOAD = 2'd0;
	localparam logic [1:0] ST_EMIT = 2'd1;
	localparam logic [1:0] ST_DUP  = 2'd2;
	localparam logic [1:0] ST_END  = 2'd3;

	// Register indexes (byte address / 4)
	localparam logic [1:0] REG_NUM_SOURCES = 2'd0;
	localparam logic [1:0] REG_REVERSE     = 2'd1;
	localparam logic [1:0] REG_DROP_DUP    = 2'd2;

	typedef struct packed {
		logic [KEY_W-1:0] record_key;
		logic             source_exhausted;
	} in_item_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [KEY_W-1:0] out_key;
		logic [SRC_W-1:0] out_source;
		logic [SRC_W-1:0] next_source;
	} out_item_t;

	// One heap entry
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [SRC_W-1:0] src;
	} entry_t;

	typedef struct packed {
		logic [CNT_W-1:0] num_sources;
		logic             reverse_order;
		logic             drop_duplicates;
	} cfg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_UP_RD,
		S_UP_CMP,
		S_LAST,
		S_DN_RD,
		S_DN_CMP,
		S_DONE
	} ctrl_state_t;

	typedef enum logic [1:0] {
		RD_LAST,
		RD_PARENT,
		RD_CHILD
	} rd_sel_t;

	// Controller to datapath
	typedef struct packed {
		logic    start;       // input beat taken
		rd_sel_t rd_sel;
		logic    wr_mov;      // park moving entry in the hole, done
		logic    wr_rda;      // parent drops into hole, hole climbs
		logic    wr_win;      // winning child rises into hole, hole descends
		logic    mov_from_rd; // last entry becomes the moving entry
		logic    finish;      // load output register
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic go_up;
		logic go_down;
		logic go_last;
		logic hole_zero;
		logic child_none;
		logic up_swap;
		logic dn_swap;
		logic out_busy;
	} stat_t;

	// True when entry a leaves the heap before entry b
	function automatic logic goes_first(entry_t a, entry_t b, logic rev);
		logic r;
		if (a.key != b.key) begin
			r = rev ? (a.key > b.key) : (a.key < b.key);
		end else begin
			r = a.src < b.src;
		end
		return r;
	endfunction

endpackage

// File: src/kmh_ctrl.sv
`timescale 1ns / 1ps

module kmh_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  kmh_pkg::stat_t stat,
	output kmh_pkg::cmd_t  cmd
);

	kmh_pkg::ctrl_state_t state_q, state_nxt;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kmh_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state and commands
	always_comb begin
		state_nxt       = state_q;
		cmd             = '0;
		cmd.rd_sel      = kmh_pkg::RD_LAST;
		in_stall        = 1'b1;
		unique case (state_q)
			kmh_pkg::S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.start = 1'b1;
					if (stat.go_up) begin
						state_nxt = kmh_pkg::S_UP_RD;
					end else if (stat.go_down) begin
						state_nxt = kmh_pkg::S_DN_RD;
					end else if (stat.go_last) begin
						state_nxt = kmh_pkg::S_LAST;
					end else begin
						state_nxt = kmh_pkg::S_DONE;
					end
				end
			end
			kmh_pkg::S_UP_RD: begin
				if (stat.hole_zero) begin
					cmd.wr_mov = 1'b1;
					state_nxt  = kmh_pkg::S_DONE;
				end else begin
					cmd.rd_sel = kmh_pkg::RD_PARENT;
					state_nxt  = kmh_pkg::S_UP_CMP;
				end
			end
			kmh_pkg::S_UP_CMP: begin
				if (stat.up_swap) begin
					cmd.wr_rda = 1'b1;
					state_nxt  = kmh_pkg::S_UP_RD;
				end else begin
					cmd.wr_mov = 1'b1;
					state_nxt  = kmh_pkg::S_DONE;
				end
			end
			kmh_pkg::S_LAST: begin
				cmd.mov_from_rd = 1'b1;
				state_nxt       = kmh_pkg::S_DN_RD;
			end
			kmh_pkg::S_DN_RD: begin
				if (stat.child_none) begin
					cmd.wr_mov = 1'b1;
					state_nxt  = kmh_pkg::S_DONE;
				end else begin
					cmd.rd_sel = kmh_pkg::RD_CHILD;
					state_nxt  = kmh_pkg::S_DN_CMP;
				end
			end
			kmh_pkg::S_DN_CMP: begin
				if (stat.dn_swap) begin
					cmd.wr_win = 1'b1;
					state_nxt  = kmh_pkg::S_DN_RD;
				end else begin
					cmd.wr_mov = 1'b1;
					state_nxt  = kmh_pkg::S_DONE;
				end
			end
			kmh_pkg::S_DONE: begin
				if (!stat.out_busy) begin
					cmd.finish = 1'b1;
					state_nxt  = kmh_pkg::S_IDLE;
				end
			end
			default: begin
				state_nxt = kmh_pkg::S_IDLE;
			end
		endcase
	end

endmodule

// File: src/kmh_dpath.sv
`timescale 1ns / 1ps

module kmh_dpath (
	input  logic               clk,
	input  logic               arst_n,
	input  kmh_pkg::cfg_t      cfg,
	input  logic               restart,
	input  kmh_pkg::in_item_t  in_data,
	input  kmh_pkg::cmd_t      cmd,
	output kmh_pkg::stat_t     stat,
	output logic               out_valid,
	input  logic               out_stall,
	output kmh_pkg::out_item_t out_data
);

	localparam int SW = kmh_pkg::SRC_W;
	localparam int CW = kmh_pkg::CNT_W;

	// Heap storage: two registered read ports, one write port
	kmh_pkg::entry_t heap_mem_q [kmh_pkg::NUM_SRC];
	kmh_pkg::entry_t rd_a_q, rd_b_q;

	logic [CW-1:0]            cnt_q, loaded_q;
	logic [kmh_pkg::KEY_W-1:0] last_key_q;
	logic                     have_last_q;
	kmh_pkg::entry_t          top_q, mov_q;
	logic [SW-1:0]            hole_q;
	logic [1:0]               res_status_q;
	logic [kmh_pkg::KEY_W-1:0] res_key_q;
	logic [SW-1:0]            res_src_q;
	logic                     out_valid_q;
	kmh_pkg::out_item_t       out_q;

	logic            is_load, is_empty, is_dup, exh;
	logic [CW-1:0]   cnt_m1;
	logic [SW-1:0]   parent_idx, raddr_a, raddr_b, win_idx, next_src;
	logic [SW+1:0]   lc_idx, rc_idx;
	logic            has_right, right_first, wr_en;
	kmh_pkg::entry_t win, wr_data;

	// Decode of the current item against heap state
	assign exh      = in_data.source_exhausted;
	assign is_load  = loaded_q < cfg.num_sources;
	assign is_empty = cnt_q == '0;
	assign is_dup   = cfg.drop_duplicates && have_last_q && (top_q.key == last_key_q);
	assign cnt_m1   = cnt_q - CW'(1);

	// Tree neighbors of the hole
	assign parent_idx = (hole_q - SW'(1)) >> 1;
	assign lc_idx     = {1'b0, hole_q, 1'b1};
	assign rc_idx     = lc_idx + (SW+2)'(1);
	assign has_right  = rc_idx < (SW+2)'(cnt_q);
	assign right_first = has_right && kmh_pkg::goes_first(rd_b_q, rd_a_q, cfg.reverse_order);
	assign win        = right_first ? rd_b_q : rd_a_q;
	assign win_idx    = right_first ? rc_idx[SW-1:0] : lc_idx[SW-1:0];

	// Status to controller
	always_comb begin
		stat            = '0;
		stat.go_up      = is_load && !exh;
		stat.go_down    = !is_load && !is_empty && !exh;
		stat.go_last    = !is_load && !is_empty && exh && (cnt_q != CW'(1));
		stat.hole_zero  = hole_q == '0;
		stat.child_none = lc_idx >= (SW+2)'(cnt_q);
		stat.up_swap    = kmh_pkg::goes_first(mov_q, rd_a_q, cfg.reverse_order);
		stat.dn_swap    = kmh_pkg::goes_first(win, mov_q, cfg.reverse_order);
		stat.out_busy   = out_valid_q && out_stall;
	end

	// Read address select
	always_comb begin
		unique case (cmd.rd_sel)
			kmh_pkg::RD_LAST:   raddr_a = cnt_m1[SW-1:0];
			kmh_pkg::RD_PARENT: raddr_a = parent_idx;
			kmh_pkg::RD_CHILD:  raddr_a = lc_idx[SW-1:0];
			default:            raddr_a = lc_idx[SW-1:0];
		endcase
	end
	assign raddr_b = rc_idx[SW-1:0];

	// Write port
	assign wr_en   = cmd.wr_mov || cmd.wr_rda || cmd.wr_win;
	assign wr_data = cmd.wr_mov ? mov_q : (cmd.wr_rda ? rd_a_q : win);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			heap_mem_q[hole_q] <= wr_data;
		end
		rd_a_q <= heap_mem_q[raddr_a];
		rd_b_q <= heap_mem_q[raddr_b];
	end

	// Counters and duplicate tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			loaded_q    <= '0;
			last_key_q  <= '0;
			have_last_q <= 1'b0;
		end else if (restart) begin
			cnt_q       <= '0;
			loaded_q    <= '0;
			last_key_q  <= '0;
			have_last_q <= 1'b0;
		end else if (cmd.start) begin
			if (is_load) begin
				loaded_q <= loaded_q + CW'(1);
				if (!exh) begin
					cnt_q <= cnt_q + CW'(1);
				end
			end else if (!is_empty) begin
				if (!is_dup) begin
					last_key_q  <= top_q.key;
					have_last_q <= 1'b1;
				end
				if (exh) begin
					cnt_q <= cnt_m1;
				end
			end
		end
	end

	// Moving entry, hole position, root mirror, pending result
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			if (is_load) begin
				mov_q        <= '{key: in_data.record_key, src: loaded_q[SW-1:0]};
				hole_q       <= cnt_q[SW-1:0];
				res_status_q <= kmh_pkg::ST_LOAD;
				res_key_q    <= '0;
				res_src_q    <= '0;
			end else if (is_empty) begin
				res_status_q <= kmh_pkg::ST_END;
				res_key_q    <= '0;
				res_src_q    <= '0;
			end else begin
				mov_q        <= '{key: in_data.record_key, src: top_q.src};
				hole_q       <= '0;
				res_status_q <= is_dup ? kmh_pkg::ST_DUP : kmh_pkg::ST_EMIT;
				res_key_q    <= top_q.key;
				res_src_q    <= top_q.src;
			end
		end else if (cmd.mov_from_rd) begin
			mov_q <= rd_a_q;
		end else if (cmd.wr_rda) begin
			hole_q <= parent_idx;
		end else if (cmd.wr_win) begin
			hole_q <= win_idx;
		end
		if (wr_en && (hole_q == '0)) begin
			top_q <= wr_data;
		end
	end

	// Source expected by the next beat
	always_comb begin
		if (is_load) begin
			next_src = loaded_q[SW-1:0];
		end else if (!is_empty) begin
			next_src = top_q.src;
		end else begin
			next_src = '0;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_q.status      <= res_status_q;
			out_q.out_key     <= res_key_q;
			out_q.out_source  <= res_src_q;
			out_q.next_source <= next_src;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// File: src/kway_merge_heap_core.sv
// Operation: an accepted input beat moves its entry through the heap one tree level
//   at a time, first reading the parent or children, then comparing and writing; the
//   entry is parked at the root, at a leaf or where a compare stops. On removal the
//   last entry is fetched first. The result is then posted to the output register.
// Items are taken one at a time: no new beat is taken until the heap work for the
//   last one is done and its result posted. A new beat is taken while a
//   finished result still waits in the output register.
// Reset: arst_n clears the heap count, load count, last key and handshakes;
//   num_sources resets to 16, reverse_order and drop_duplicates to 0.
`timescale 1ns / 1ps

module kway_merge_heap_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  kmh_pkg::in_item_t             in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output kmh_pkg::out_item_t            out_data,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [kmh_pkg::PADDR_W-1:0]   paddr,
	input  logic [kmh_pkg::PDATA_W-1:0]   pwdata,
	output logic [kmh_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);

	localparam int CW = kmh_pkg::CNT_W;

	kmh_pkg::cfg_t  cfg_q;
	kmh_pkg::cmd_t  cmd;
	kmh_pkg::stat_t stat;
	logic           wr_beat, restart;
	logic [1:0]     reg_idx;
	logic [kmh_pkg::NSRC_W-1:0] nsrc_raw;
	logic [CW-1:0]  nsrc_clamped;

	assign pready  = 1'b1;
	assign wr_beat = psel && penable && pwrite && pready;
	assign reg_idx = paddr[3:2];
	assign restart = wr_beat && (reg_idx == kmh_pkg::REG_NUM_SOURCES);

	// Clamp source count to 1..NUM_SRC
	assign nsrc_raw = pwdata[kmh_pkg::NSRC_W-1:0];
	always_comb begin
		if (nsrc_raw == '0) begin
			nsrc_clamped = CW'(1);
		end else if (CW'(nsrc_raw) > CW'(kmh_pkg::NUM_SRC)) begin
			nsrc_clamped = CW'(kmh_pkg::NUM_SRC);
		end else begin
			nsrc_clamped = CW'(nsrc_raw);
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.num_sources     <= CW'(kmh_pkg::NUM_SRC);
			cfg_q.reverse_order   <= 1'b0;
			cfg_q.drop_duplicates <= 1'b0;
		end else if (wr_beat) begin
			unique case (reg_idx)
				kmh_pkg::REG_NUM_SOURCES: cfg_q.num_sources     <= nsrc_clamped;
				kmh_pkg::REG_REVERSE:     cfg_q.reverse_order   <= pwdata[0];
				kmh_pkg::REG_DROP_DUP:    cfg_q.drop_duplicates <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Register readback
	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			kmh_pkg::REG_NUM_SOURCES: prdata = kmh_pkg::PDATA_W'(cfg_q.num_sources);
			kmh_pkg::REG_REVERSE:     prdata = kmh_pkg::PDATA_W'(cfg_q.reverse_order);
			kmh_pkg::REG_DROP_DUP:    prdata = kmh_pkg::PDATA_W'(cfg_q.drop_duplicates);
			default:                  prdata = '0;
		endcase
	end

	kmh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	kmh_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.restart   (restart),
		.in_data   (in_data),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

// File: src/kmh_checker.sv
`timescale 1ns / 1ps

module kmh_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input kmh_pkg::out_item_t out_data,
	input logic               out_valid,
	input logic               out_stall
);

	// One item at a time: a taken beat closes the input
	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input open right after a beat");

	// A new result only follows work in progress
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without preceding work");

	// Load and end results carry no record
	a_no_record: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status == kmh_pkg::ST_LOAD ||
			out_data.status == kmh_pkg::ST_END) |->
		out_data.out_key == '0 && out_data.out_source == '0)
		else $error("record fields set on load or end status");

	// Stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// End status always names source zero next
	a_end_next: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == kmh_pkg::ST_END |-> out_data.next_source == '0)
		else $error("end status with nonzero next source");

endmodule

bind kway_merge_heap_core kmh_checker u_kmh_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_data  (out_data),
	.out_valid (out_valid),
	.out_stall (out_stall)
);

// File: tb/sv/tb_kway_merge_heap_core.sv
`timescale 1ns / 1ps

module tb_kway_merge_heap_core;

	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam int unsigned QUIET_LIMIT = 5000;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned SETTLE_CYCLES = 20;
	localparam int unsigned ITEM_TARGET = 1200;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         in_valid = 1'b0;
	logic                         in_stall;
	kmh_pkg::in_item_t            in_data = '0;
	logic                         out_valid;
	logic                         out_stall = 1'b0;
	kmh_pkg::out_item_t           out_data;
	logic                         psel = 1'b0;
	logic                         penable = 1'b0;
	logic                         pwrite = 1'b0;
	logic [kmh_pkg::PADDR_W-1:0]  paddr = '0;
	logic [kmh_pkg::PDATA_W-1:0]  pwdata = '0;
	logic [kmh_pkg::PDATA_W-1:0]  prdata;
	logic                         pready;

	kway_merge_heap_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shared between stimulus, driver and monitor
	kmh_pkg::in_item_t  pend_items[$];
	kmh_pkg::out_item_t merge_exp[$];
	int unsigned n_items = 0;
	int unsigned errs = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned hold_asked = 0;

	// Shadow of the merge heap and its settings
	logic [kmh_pkg::KEY_W-1:0] hk [kmh_pkg::NUM_SRC];
	logic [kmh_pkg::SRC_W-1:0] hs [kmh_pkg::NUM_SRC];
	int unsigned               hcnt = 0;
	int unsigned               lcnt = 0;
	logic [kmh_pkg::KEY_W-1:0] last_k = '0;
	logic                      have_last = 1'b0;
	int unsigned               cfg_n = kmh_pkg::NUM_SRC;
	logic                      cfg_rev = 1'b0;
	logic                      cfg_drop = 1'b0;

	// Entry a leaves the heap before entry b
	function automatic logic ahead(int unsigned a, int unsigned b);
		if (hk[a] != hk[b]) begin
			return cfg_rev ? (hk[a] > hk[b]) : (hk[a] < hk[b]);
		end
		return hs[a] < hs[b];
	endfunction

	function automatic void swap_ent(int unsigned a, int unsigned b);
		logic [kmh_pkg::KEY_W-1:0] k;
		logic [kmh_pkg::SRC_W-1:0] s;
		k = hk[a];
		s = hs[a];
		hk[a] = hk[b];
		hs[a] = hs[b];
		hk[b] = k;
		hs[b] = s;
	endfunction

	// Expected result of one input beat; advances the shadow heap
	function automatic kmh_pkg::out_item_t merge_step(kmh_pkg::in_item_t it);
		kmh_pkg::out_item_t r;
		int unsigned        pos, up, c;
		logic               done;
		r = '0;
		if (lcnt < cfg_n) begin
			// loading heads; an empty source gets no entry
			if (!it.source_exhausted && hcnt < kmh_pkg::NUM_SRC) begin
				hk[hcnt] = it.record_key;
				hs[hcnt] = kmh_pkg::SRC_W'(lcnt);
				pos = hcnt;
				hcnt++;
				done = 1'b0;
				while (pos > 0 && !done) begin
					up = (pos - 1) / 2;
					if (ahead(pos, up)) begin
						swap_ent(pos, up);
						pos = up;
					end else begin
						done = 1'b1;
					end
				end
			end
			lcnt++;
			r.status = kmh_pkg::ST_LOAD;
		end else if (hcnt == 0) begin
			r.status = kmh_pkg::ST_END;
		end else begin
			r.out_key = hk[0];
			r.out_source = hs[0];
			if (cfg_drop && have_last && hk[0] == last_k) begin
				r.status = kmh_pkg::ST_DUP;
			end else begin
				r.status = kmh_pkg::ST_EMIT;
				last_k = hk[0];
				have_last = 1'b1;
			end
			// refill or remove the top, then sift down
			if (it.source_exhausted) begin
				hcnt--;
				if (hcnt > 0) begin
					hk[0] = hk[hcnt];
					hs[0] = hs[hcnt];
				end
			end else begin
				hk[0] = it.record_key;
			end
			pos = 0;
			done = 1'b0;
			while (!done) begin
				c = 2 * pos + 1;
				if (c >= hcnt) begin
					done = 1'b1;
				end else begin
					if (c + 1 < hcnt && ahead(c + 1, c)) c = c + 1;
					if (ahead(c, pos)) begin
						swap_ent(pos, c);
						pos = c;
					end else begin
						done = 1'b1;
					end
				end
			end
		end
		if (lcnt < cfg_n) r.next_source = kmh_pkg::SRC_W'(lcnt);
		else if (hcnt > 0) r.next_source = hs[0];
		else r.next_source = '0;
		return r;
	endfunction

	function automatic void apply_cfg(logic [1:0] idx, logic [31:0] val);
		int unsigned v;
		case (idx)
			kmh_pkg::REG_NUM_SOURCES: begin
				v = 32'(val[4:0]);
				if (v < 1) v = 1;
				if (v > kmh_pkg::NUM_SRC) v = kmh_pkg::NUM_SRC;
				cfg_n = v;
				// restart: heap, load count and last key cleared
				hcnt = 0;
				lcnt = 0;
				last_k = '0;
				have_last = 1'b0;
			end
			kmh_pkg::REG_REVERSE: cfg_rev = val[0];
			kmh_pkg::REG_DROP_DUP: cfg_drop = val[0];
			default: ;
		endcase
	endfunction

	// Input driver: hold a stalled beat, otherwise offer the next one or idle
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) merge_exp.push_back(merge_step(in_data));
			if (!in_valid || !in_stall) begin
				if (pend_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					in_data <= pend_items.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor and receiver stall
	int unsigned hold_seen = 0;
	int unsigned hold_left = 0;
	always @(posedge clk) begin
		kmh_pkg::out_item_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (merge_exp.size() == 0) begin
					$error("result beat with nothing expected: %h", out_data);
					errs++;
				end else begin
					want = merge_exp.pop_front();
					if (out_data.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, out_data.status);
						errs++;
					end
					if (out_data.out_key !== want.out_key) begin
						$error("out_key: expected %h, got %h", want.out_key, out_data.out_key);
						errs++;
					end
					if (out_data.out_source !== want.out_source) begin
						$error("out_source: expected %0d, got %0d", want.out_source,
							out_data.out_source);
						errs++;
					end
					if (out_data.next_source !== want.next_source) begin
						$error("next_source: expected %0d, got %0d", want.next_source,
							out_data.next_source);
						errs++;
					end
				end
			end
			// long hold-off on request, otherwise random stall
			if (hold_seen != hold_asked) begin
				hold_seen = hold_asked;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) hold_left--;
			out_stall <= (hold_left > 0) || ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	// Watchdog: too long without any beat on either channel
	int unsigned quiet = 0;
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet == QUIET_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Wait until every beat is sent and answered, then let the block settle
	task automatic wait_idle();
		do @(negedge clk); while (pend_items.size() != 0 || in_valid || merge_exp.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		apply_cfg(idx, val);
	endtask

	task automatic push_beat(logic [kmh_pkg::KEY_W-1:0] key, logic gone);
		kmh_pkg::in_item_t it;
		it.record_key = key;
		it.source_exhausted = gone;
		pend_items.push_back(it);
		n_items++;
	endtask

	// Next record of a sorted stream: unless noisy, keys never move against the merge order
	task automatic add_record(ref logic [kmh_pkg::KEY_W-1:0] walk, input logic noisy,
		input logic gone);
		logic [kmh_pkg::KEY_W-1:0] step;
		case ($urandom_range(0, 9))
			0, 1, 2: step = '0;
			3, 4, 5: step = $urandom_range(1, 15);
			6, 7, 8: step = $urandom_range(16, 1 << 20);
			default: step = $urandom >> 8;
		endcase
		walk = (walk > 32'hFFFF_FFFF - step) ? 32'hFFFF_FFFF : walk + step;
		if (gone || noisy) push_beat($urandom, gone);
		else push_beat(cfg_rev ? ~walk : walk, gone);
	endtask

	// One merge from restart to drained heap, plus up to two beats past the end
	task automatic run_episode(logic [31:0] n_val, int unsigned grow, logic noisy,
		logic squeeze);
		int unsigned               ex_pct;
		logic [kmh_pkg::KEY_W-1:0] walk;
		wait_idle();
		if ($urandom_range(0, 1)) cfg_write(kmh_pkg::REG_REVERSE, $urandom);
		if ($urandom_range(0, 1)) cfg_write(kmh_pkg::REG_DROP_DUP, $urandom);
		if ($urandom_range(0, 9) == 0) cfg_write(REG_UNUSED, $urandom);
		cfg_write(kmh_pkg::REG_NUM_SOURCES, n_val);
		ex_pct = $urandom_range(5, 35);
		walk = $urandom >> $urandom_range(0, 31);
		if (squeeze) hold_asked++;
		for (int i = 0; i < cfg_n; i++) add_record(walk, noisy, $urandom_range(0, 99) < 15);
		for (int i = 0; i < cfg_n * grow; i++) begin
			add_record(walk, noisy, $urandom_range(0, 99) < ex_pct);
		end
		// enough exhausted beats to drain whatever is left
		for (int i = 0; i < cfg_n; i++) add_record(walk, noisy, 1'b1);
		repeat ($urandom_range(0, 2)) add_record(walk, noisy, $urandom_range(0, 1));
	endtask

	initial begin
		logic [31:0] n_val;
		int unsigned r;
		logic        squeezed;
		squeezed = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// single source (zero acts as one): extreme keys, then past the end
		cfg_write(kmh_pkg::REG_NUM_SOURCES, 32'd0);
		push_beat(32'h0000_0000, 1'b0);
		push_beat(32'hFFFF_FFFF, 1'b0);
		push_beat(32'h0000_0000, 1'b1);
		push_beat($urandom, 1'b0);

		// duplicates dropped, an empty source, tie on key between sources
		wait_idle();
		cfg_write(kmh_pkg::REG_DROP_DUP, 32'd1);
		cfg_write(kmh_pkg::REG_NUM_SOURCES, 32'd3);
		push_beat(32'd5, 1'b0);
		push_beat($urandom, 1'b1);
		push_beat(32'd5, 1'b0);
		push_beat(32'd5, 1'b0);
		push_beat(32'd7, 1'b0);
		push_beat($urandom, 1'b1);
		push_beat($urandom, 1'b1);
		push_beat($urandom, 1'b1);
		push_beat($urandom, 1'b0);

		// every source empty
		wait_idle();
		cfg_write(kmh_pkg::REG_NUM_SOURCES, 32'd2);
		push_beat($urandom, 1'b1);
		push_beat($urandom, 1'b1);
		push_beat($urandom, 1'b0);

		// order flipped mid-merge without a rebuild
		wait_idle();
		cfg_write(kmh_pkg::REG_DROP_DUP, 32'd0);
		cfg_write(kmh_pkg::REG_NUM_SOURCES, 32'd2);
		push_beat(32'd10, 1'b0);
		push_beat(32'd20, 1'b0);
		push_beat(32'd30, 1'b0);
		wait_idle();
		cfg_write(kmh_pkg::REG_REVERSE, 32'd1);
		push_beat($urandom, 1'b1);
		push_beat($urandom, 1'b1);

		// restart in the middle of loading
		wait_idle();
		cfg_write(kmh_pkg::REG_NUM_SOURCES, 32'd2);
		push_beat(32'd1, 1'b0);
		wait_idle();
		cfg_write(kmh_pkg::REG_NUM_SOURCES, 32'd1);
		push_beat(32'd9, 1'b0);
		push_beat($urandom, 1'b1);

		// random merges across idling phases
		while (n_items < ITEM_TARGET) begin
			case (n_items * 4 / ITEM_TARGET)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
				default: begin send_idle_pct = 22; recv_stall_pct = 22; end
			endcase
			if (!squeezed && n_items > 100) begin
				// receiver holds off while a full merge is offered back to back
				squeezed = 1'b1;
				run_episode(32'd16, 4, 1'b0, 1'b1);
			end else begin
				r = $urandom_range(0, 19);
				if (r == 0) n_val = 32'd0;
				else if (r == 1) n_val = $urandom_range(17, 31);
				else if (r == 2) n_val = 32'd16 | ($urandom << 5);
				else if (r < 6) n_val = $urandom_range(9, 16);
				else n_val = $urandom_range(1, 8);
				run_episode(n_val, $urandom_range(1, 6), $urandom_range(0, 99) < 15, 1'b0);
			end
		end

		wait_idle();
		if (errs == 0 && merge_exp.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
